/* hdl/sha256md_pkg.sv */
// Package for the SHA-256 message digest block.
// Holds the round constants, the initial hash values and the command and
// status structs shared by the controller and the datapath.
package sha256md_pkg;

    localparam int BLOCK_BYTES = 64;
    localparam int SCHED_WORDS = 16;
    localparam int HASH_WORDS  = 8;
    localparam int ROUNDS      = 64;

    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam logic [31:0] K_TABLE [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] H_INIT [HASH_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       wr_byte;    // store the accepted byte at the fill position
        logic       pad_first;  // 0x80 marker, zeros, and length if it fits
        logic       pad_len;    // zero block with the length at the end
        logic       load_vars;  // working variables take the hash state
        logic       do_round;   // one compression round
        logic       add_hash;   // fold working variables into the hash
        logic       restart;    // initial hash, length cleared
        logic [5:0] round_idx;
        logic [2:0] word_idx;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic fill_end;  // the next byte completes the block
        logic fill_hi;   // no room for the length in this block
    } status_t;

endpackage

/* hdl/sha256md_in_if.sv */
// Message input channel of the SHA-256 digest block.
// Valid/ready handshake carrying at most one message byte per item; no dependencies.
interface sha256md_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;

    modport source (output valid, output data_byte, output has_byte, output last,
                    input ready);
    modport sink (input valid, input data_byte, input has_byte, input last,
                  output ready);
endinterface

/* hdl/sha256md_out_if.sv */
// Digest output channel of the SHA-256 digest block.
// Valid/ready handshake carrying one 32-bit digest word per item; no dependencies.
interface sha256md_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink (input valid, input digest_word, input word_index,
                  input last_word, output ready);
endinterface

/* hdl/sha256md_datapath.sv */
// Datapath of the SHA-256 digest block: message window, round logic,
// hash state and bit length counter. Depends on sha256md_pkg.
module sha256md_datapath
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  sha256md_pkg::cmd_t   cmd,
    input  logic [7:0]           data_byte,
    output sha256md_pkg::status_t status,
    output logic [31:0]          digest_word,
    output logic [2:0]           word_index,
    output logic                 last_word
);

    logic [31:0] sched_reg [sha256md_pkg::SCHED_WORDS];
    logic [31:0] sched_next [sha256md_pkg::SCHED_WORDS];
    logic [31:0] vars_reg [sha256md_pkg::HASH_WORDS];
    logic [31:0] vars_next [sha256md_pkg::HASH_WORDS];
    logic [31:0] hash_reg [sha256md_pkg::HASH_WORDS];
    logic [31:0] hash_next [sha256md_pkg::HASH_WORDS];
    logic [63:0] bitlen_reg;
    logic [63:0] bitlen_next;

    logic [5:0]  fill;
    logic [31:0] sum1, sum0, choose, major, t1, t2, w_new;

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

    // The block fill is the byte count modulo 64.
    assign fill            = bitlen_reg[8:3];
    assign status.fill_end = (fill == 6'd63);
    assign status.fill_hi  = (fill[5:3] == 3'b111);

    assign sum1   = big_sigma1(vars_reg[4]);
    assign choose = (vars_reg[4] & vars_reg[5]) ^ (~vars_reg[4] & vars_reg[6]);
    assign sum0   = big_sigma0(vars_reg[0]);
    assign major  = (vars_reg[0] & vars_reg[1]) ^ (vars_reg[0] & vars_reg[2])
                  ^ (vars_reg[1] & vars_reg[2]);
    assign t1     = vars_reg[7] + sum1 + choose
                  + sha256md_pkg::K_TABLE[cmd.round_idx] + sched_reg[0];
    assign t2     = sum0 + major;

    // The window holds W[t] .. W[t+15]; each round pushes W[t+16].
    assign w_new  = small_sigma1(sched_reg[14]) + sched_reg[9]
                  + small_sigma0(sched_reg[1]) + sched_reg[0];

    always_comb
    begin
        sched_next = sched_reg;
        if (cmd.do_round)
        begin
            for (int i = 0; i < sha256md_pkg::SCHED_WORDS - 1; i++)
            begin
                sched_next[i] = sched_reg[i + 1];
            end
            sched_next[sha256md_pkg::SCHED_WORDS - 1] = w_new;
        end
        else
        begin
            for (int k = 0; k < sha256md_pkg::BLOCK_BYTES; k++)
            begin
                if (cmd.wr_byte && (fill == 6'(k)))
                begin
                    sched_next[k / 4][8 * (3 - (k % 4)) +: 8] = data_byte;
                end
                if (cmd.pad_first)
                begin
                    if (fill == 6'(k))
                    begin
                        sched_next[k / 4][8 * (3 - (k % 4)) +: 8] = sha256md_pkg::PAD_MARK;
                    end
                    else if (6'(k) > fill)
                    begin
                        if ((k >= 56) && !status.fill_hi)
                        begin
                            sched_next[k / 4][8 * (3 - (k % 4)) +: 8] =
                                bitlen_reg[8 * ((63 - k) % 8) +: 8];
                        end
                        else
                        begin
                            sched_next[k / 4][8 * (3 - (k % 4)) +: 8] = 8'h00;
                        end
                    end
                end
                if (cmd.pad_len)
                begin
                    if (k >= 56)
                    begin
                        sched_next[k / 4][8 * (3 - (k % 4)) +: 8] =
                            bitlen_reg[8 * ((63 - k) % 8) +: 8];
                    end
                    else
                    begin
                        sched_next[k / 4][8 * (3 - (k % 4)) +: 8] = 8'h00;
                    end
                end
            end
        end
    end

    always_comb
    begin
        vars_next = vars_reg;
        if (cmd.load_vars)
        begin
            vars_next = hash_reg;
        end
        else if (cmd.do_round)
        begin
            vars_next[7] = vars_reg[6];
            vars_next[6] = vars_reg[5];
            vars_next[5] = vars_reg[4];
            vars_next[4] = vars_reg[3] + t1;
            vars_next[3] = vars_reg[2];
            vars_next[2] = vars_reg[1];
            vars_next[1] = vars_reg[0];
            vars_next[0] = t1 + t2;
        end
    end

    always_comb
    begin
        hash_next   = hash_reg;
        bitlen_next = bitlen_reg;
        if (cmd.restart)
        begin
            hash_next   = sha256md_pkg::H_INIT;
            bitlen_next = 64'd0;
        end
        else
        begin
            if (cmd.add_hash)
            begin
                for (int i = 0; i < sha256md_pkg::HASH_WORDS; i++)
                begin
                    hash_next[i] = hash_reg[i] + vars_reg[i];
                end
            end
            if (cmd.wr_byte)
            begin
                bitlen_next = bitlen_reg + 64'd8;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg   <= sha256md_pkg::H_INIT;
            bitlen_reg <= 64'd0;
        end
        else
        begin
            hash_reg   <= hash_next;
            bitlen_reg <= bitlen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sched_reg <= sched_next;
        vars_reg  <= vars_next;
    end

    assign digest_word = hash_reg[cmd.word_idx];
    assign word_index  = cmd.word_idx;
    assign last_word   = (cmd.word_idx == 3'd7);

endmodule

/* hdl/sha256md_ctrl.sv */
// Controller of the SHA-256 digest block: sequences byte intake, padding,
// the 64 compression rounds and digest output. Depends on sha256md_pkg.
module sha256md_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_has_byte,
    input  logic                  in_last,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  sha256md_pkg::status_t status,
    output sha256md_pkg::cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_ADD   = 3'd3;
    localparam logic [2:0] ST_PAD   = 3'd4;
    localparam logic [2:0] ST_PAD2  = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    // Which block the running compression belongs to.
    localparam logic [1:0] PH_DATA  = 2'd0;
    localparam logic [1:0] PH_PAD1  = 2'd1;
    localparam logic [1:0] PH_FINAL = 2'd2;

    logic [2:0] state_reg, state_next;
    logic [1:0] phase_reg, phase_next;
    logic       pend_reg, pend_next;
    logic [5:0] round_reg, round_next;
    logic [2:0] word_reg, word_next;
    logic       in_accept;
    logic       out_accept;

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = (state_reg == ST_OUT);
    assign in_accept  = in_valid && in_ready;
    assign out_accept = out_valid && out_ready;

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        pend_next  = pend_reg;
        round_next = round_reg;
        word_next  = word_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (in_has_byte && status.fill_end)
                    begin
                        state_next = ST_LOAD;
                        phase_next = PH_DATA;
                        pend_next  = in_last;
                    end
                    else if (in_last)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_LOAD:
            begin
                round_next = 6'd0;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                round_next = round_reg + 6'd1;
                if (round_reg == 6'd63)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                priority case (phase_reg)
                    PH_PAD1:  state_next = ST_PAD2;
                    PH_FINAL: state_next = ST_OUT;
                    default:  state_next = pend_reg ? ST_PAD : ST_IDLE;
                endcase
                word_next = 3'd0;
            end
            ST_PAD:
            begin
                state_next = ST_LOAD;
                phase_next = status.fill_hi ? PH_PAD1 : PH_FINAL;
            end
            ST_PAD2:
            begin
                state_next = ST_LOAD;
                phase_next = PH_FINAL;
            end
            ST_OUT:
            begin
                if (out_accept)
                begin
                    word_next = word_reg + 3'd1;
                    if (word_reg == 3'd7)
                    begin
                        state_next = ST_IDLE;
                        pend_next  = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_DATA;
            pend_reg  <= 1'b0;
            round_reg <= 6'd0;
            word_reg  <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            pend_reg  <= pend_next;
            round_reg <= round_next;
            word_reg  <= word_next;
        end
    end

    always_comb
    begin
        cmd           = '0;
        cmd.wr_byte   = in_accept && in_has_byte;
        cmd.pad_first = (state_reg == ST_PAD);
        cmd.pad_len   = (state_reg == ST_PAD2);
        cmd.load_vars = (state_reg == ST_LOAD);
        cmd.do_round  = (state_reg == ST_ROUND);
        cmd.add_hash  = (state_reg == ST_ADD);
        cmd.restart   = out_accept && (word_reg == 3'd7);
        cmd.round_idx = round_reg;
        cmd.word_idx  = word_reg;
    end

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output active together");

    a_round_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |=> (state_reg == ST_ROUND) && (round_reg == 6'd0))
        else $error("compression did not start at round zero");

    a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) && (round_reg == 6'd63) |=> (state_reg == ST_ADD))
        else $error("compression did not end after the last round");

    a_digest_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_accept && (word_reg == 3'd7) |=> (state_reg == ST_IDLE) && !pend_reg)
        else $error("block did not return to intake after the digest");

    a_out_first: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> (word_reg == 3'd0))
        else $error("digest output did not begin at word zero");
`endif

endmodule

/* hdl/sha256_message_digest.sv */
// Top level of the SHA-256 message digest block.
// Joins sha256md_ctrl and sha256md_datapath; uses sha256md_pkg and the
// sha256md_in_if / sha256md_out_if channel interfaces.
//
// Usage:
//   msg carries one item per byte: data_byte with has_byte set, and last on
//   the final item. A last item with has_byte clear ends the message without
//   a byte, so an empty message is a single such item.
//   digest then delivers eight items, word_index 0 to 7, most significant
//   word first, last_word set on the eighth.
// Timing:
//   The 64th byte of a block starts a compression (load, 64 rounds, one per
//   cycle through the shared round unit, then the hash update), during which
//   msg is not ready. After last, padding runs one more compression, or two
//   when the length no longer fits in the current block; then the digest
//   words follow, one per cycle while digest is ready.
//   A stall on digest holds the current word; msg stays not ready until the
//   eighth word is taken, after which the block is set up for a new message.
// Reset: the hash state returns to the initial values and the length to zero.
module sha256_message_digest
(
    input logic            clk,
    input logic            rst_n,
    sha256md_in_if.sink    msg,
    sha256md_out_if.source digest
);

    sha256md_pkg::cmd_t    cmd;
    sha256md_pkg::status_t status;

    sha256md_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (msg.valid),
        .in_has_byte (msg.has_byte),
        .in_last     (msg.last),
        .in_ready    (msg.ready),
        .out_valid   (digest.valid),
        .out_ready   (digest.ready),
        .status      (status),
        .cmd         (cmd)
    );

    sha256md_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .data_byte   (msg.data_byte),
        .status      (status),
        .digest_word (digest.digest_word),
        .word_index  (digest.word_index),
        .last_word   (digest.last_word)
    );

endmodule

/* verif/sha256_message_digest_tb.sv */
// Self-checking testbench for sha256_message_digest: byte messages in, digest words out.
// Uses sha256md_pkg, the sha256md_in_if and sha256md_out_if interfaces and the RTL top level;
// a local SHA-256 predictor supplies the expected digest of every message.
module sha256_message_digest_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 200;
    localparam int RANDOM_ITEMS  = 210;

    typedef enum logic [1:0] {
        PH_RX_STALL,  // sender idles a little, receiver a lot
        PH_TX_GAP,    // sender idles a lot, receiver a little
        PH_STEADY     // neither side idles
    } phase_e;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last;
        logic       hold;   // wait until every expected digest word has arrived
        phase_e     phase;
    } msg_item_t;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last_word;
    } digest_word_t;

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    logic clk;
    logic rst_n;

    sha256md_in_if  msg ();
    sha256md_out_if digest ();

    sha256_message_digest u_top
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg),
        .digest (digest)
    );

    // Predictor state: running hash, the partly filled block and the bit count.
    logic [31:0]  hash_state [8];
    logic [7:0]   block_buf [64];
    logic [63:0]  msg_bits;

    msg_item_t    pending_items [$];
    digest_word_t expected_digest_q [$];
    msg_item_t    cur_item;
    digest_word_t want_word;
    int           rx_stall_pct;
    int           mismatches = 0;
    int           cycle_count;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic int tx_gap_pct(input phase_e ph);
        case (ph)
            PH_RX_STALL: return 18;
            PH_TX_GAP:   return 54;
            default:     return 0;
        endcase
    endfunction

    function automatic int rx_gap_pct(input phase_e ph);
        case (ph)
            PH_RX_STALL: return 54;
            PH_TX_GAP:   return 18;
            default:     return 0;
        endcase
    endfunction

    function automatic void compress_block_buf();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
        int i;
        for (i = 0; i < 16; i++)
            w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
        for (i = 16; i < 64; i++)
        begin
            s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
        e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
        for (i = 0; i < 64; i++)
        begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
                 + SHA_K[i] + w[i];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
        hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
    endfunction

    function automatic void restart_hash();
        int i;
        for (i = 0; i < 8; i++)
            hash_state[i] = SHA_IV[i];
        msg_bits = '0;
    endfunction

    // Folds one accepted item into the running hash; a last item queues the digest.
    function automatic void absorb_item(input msg_item_t it);
        logic [5:0] fill;
        digest_word_t dw;
        int i;
        if (it.has_byte)
        begin
            fill = msg_bits[8:3];
            block_buf[fill] = it.data_byte;
            msg_bits += 64'd8;
            if (fill == 6'd63)
                compress_block_buf();
        end
        if (it.last)
        begin
            fill = msg_bits[8:3];
            block_buf[fill] = 8'h80;
            for (i = int'(fill) + 1; i < 64; i++)
                block_buf[i] = 8'h00;
            // No room for the length: it goes into an extra all-zero block.
            if (fill >= 6'd56)
            begin
                compress_block_buf();
                for (i = 0; i < 64; i++)
                    block_buf[i] = 8'h00;
            end
            for (i = 0; i < 8; i++)
                block_buf[63 - i] = msg_bits[8*i +: 8];
            compress_block_buf();
            for (i = 0; i < 8; i++)
            begin
                dw.word      = hash_state[i];
                dw.index     = 3'(i);
                dw.last_word = (i == 7);
                expected_digest_q = {expected_digest_q, dw};
            end
            restart_hash();
        end
    endfunction

    task automatic add_item(input logic [7:0] data, input logic has, input logic fin,
                            input logic hold, input phase_e ph);
        msg_item_t it;
        it.data_byte = data;
        it.has_byte  = has;
        it.last      = fin;
        it.hold      = hold;
        it.phase     = ph;
        pending_items = {pending_items, it};
    endtask

    // Queues a message of nbytes random bytes with occasional ignored empty items.
    // Returns the number of items that carry a byte or end the message.
    task automatic add_message(input int nbytes, input logic hold, input phase_e ph,
                               output int counted);
        logic empty_end;
        int i;
        empty_end = (nbytes == 0) || ($urandom_range(0, 1) == 0);
        counted = 0;
        for (i = 0; i < nbytes; i++)
        begin
            if ($urandom_range(0, 11) == 0)
                add_item(8'($urandom), 1'b0, 1'b0, 1'b0, ph);
            add_item(8'($urandom), 1'b1, (i == nbytes - 1) && !empty_end,
                     hold && (i == 0), ph);
            counted++;
        end
        if (empty_end)
        begin
            add_item(8'($urandom), 1'b0, 1'b1, hold && (nbytes == 0), ph);
            counted++;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("sha256_message_digest regression: fail");
                $finish;
            end
        end
    end

    // Driver: presents queued items and predicts each one as it is accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msg.valid     <= 1'b0;
            msg.data_byte <= 8'h00;
            msg.has_byte  <= 1'b0;
            msg.last      <= 1'b0;
            rx_stall_pct  <= rx_gap_pct(PH_RX_STALL);
        end
        else if (!msg.valid || msg.ready)
        begin
            if (msg.valid)
                absorb_item(cur_item);
            if (pending_items.size() > 0
                && $urandom_range(0, 99) >= tx_gap_pct(pending_items[0].phase)
                && !(pending_items[0].hold && expected_digest_q.size() != 0))
            begin
                cur_item = pending_items.pop_front();
                msg.valid     <= 1'b1;
                msg.data_byte <= cur_item.data_byte;
                msg.has_byte  <= cur_item.has_byte;
                msg.last      <= cur_item.last;
                rx_stall_pct  <= rx_gap_pct(cur_item.phase);
            end
            else
            begin
                msg.valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each accepted digest word against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digest.ready <= 1'b0;
        end
        else
        begin
            if (digest.valid && digest.ready)
            begin
                if (expected_digest_q.size() == 0)
                begin
                    $display("%0t: unexpected digest item: expected none, actual %h idx %0d",
                             $time, digest.digest_word, digest.word_index);
                    mismatches++;
                end
                else
                begin
                    want_word = expected_digest_q.pop_front();
                    if (digest.digest_word !== want_word.word)
                    begin
                        $display("%0t: digest_word mismatch: expected %h, actual %h",
                                 $time, want_word.word, digest.digest_word);
                        mismatches++;
                    end
                    if (digest.word_index !== want_word.index)
                    begin
                        $display("%0t: word_index mismatch: expected %0d, actual %0d",
                                 $time, want_word.index, digest.word_index);
                        mismatches++;
                    end
                    if (digest.last_word !== want_word.last_word)
                    begin
                        $display("%0t: last_word mismatch: expected %b, actual %b",
                                 $time, want_word.last_word, digest.last_word);
                        mismatches++;
                    end
                end
            end
            digest.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    initial
    begin
        int counted;
        int total;
        int sel;
        int nbytes;
        phase_e ph;

        rst_n = 1'b0;
        restart_hash();

        // Directed: empty message, single extreme bytes, ignored empty items,
        // a message closed by an empty last item, and a short known string.
        add_item(8'h00, 1'b0, 1'b1, 1'b1, PH_RX_STALL);
        add_item(8'h00, 1'b1, 1'b1, 1'b0, PH_RX_STALL);
        add_item(8'hff, 1'b1, 1'b1, 1'b0, PH_RX_STALL);
        add_item(8'h5a, 1'b0, 1'b0, 1'b0, PH_RX_STALL);
        add_item(8'h61, 1'b1, 1'b0, 1'b1, PH_RX_STALL);
        add_item(8'hff, 1'b0, 1'b0, 1'b0, PH_RX_STALL);
        add_item(8'h62, 1'b1, 1'b0, 1'b0, PH_RX_STALL);
        add_item(8'h63, 1'b1, 1'b1, 1'b0, PH_RX_STALL);
        add_item(8'h00, 1'b1, 1'b0, 1'b0, PH_RX_STALL);
        add_item(8'hff, 1'b1, 1'b0, 1'b0, PH_RX_STALL);
        add_item(8'h55, 1'b1, 1'b0, 1'b0, PH_RX_STALL);
        add_item(8'haa, 1'b1, 1'b0, 1'b0, PH_RX_STALL);
        add_item(8'hff, 1'b0, 1'b1, 1'b0, PH_RX_STALL);
        add_item(8'h00, 1'b0, 1'b0, 1'b0, PH_RX_STALL);
        add_item(8'hff, 1'b0, 1'b1, 1'b1, PH_RX_STALL);

        // Random messages; lengths cluster around the block and padding boundaries.
        total = 0;
        ph = PH_RX_STALL;
        while (total < RANDOM_ITEMS)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 5)
                nbytes = $urandom_range(0, 20);
            else if (sel < 8)
                nbytes = $urandom_range(52, 66);
            else
                nbytes = $urandom_range(0, 140);
            add_message(nbytes, ($urandom_range(0, 7) == 0) || (ph != pending_items[$].phase),
                        ph, counted);
            total += counted;
            if (total >= RANDOM_ITEMS * 2 / 3)
                ph = PH_STEADY;
            else if (total >= RANDOM_ITEMS / 3)
                ph = PH_TX_GAP;
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || msg.valid || expected_digest_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("sha256_message_digest regression: pass");
        else
            $display("sha256_message_digest regression: fail");
        $finish;
    end

endmodule

/* sha256_message_digest.f */
hdl/sha256md_pkg.sv
hdl/sha256md_in_if.sv
hdl/sha256md_out_if.sv
hdl/sha256md_datapath.sv
hdl/sha256md_ctrl.sv
hdl/sha256_message_digest.sv
verif/sha256_message_digest_tb.sv
